// ===== rtl/owm_pkg.sv =====
// Shared types and constants of the 1-Wire bus master.
package owm_pkg;

    localparam int LONG_W = 10;
    localparam int SHORT_W = 8;
    localparam int KIND_W = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int BITS_W = 4;

    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RESET   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WR_BYTE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RD_BYTE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WR_BIT  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RD_BIT  = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_ONE_LOW = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_ZERO_LOW = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_SLOT    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_LOW      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_SAMPLE   = 3'd7;

    localparam logic [LONG_W-1:0]  DEF_RESET_LOW      = 10'd480;
    localparam logic [LONG_W-1:0]  DEF_PRESENCE_WAIT  = 10'd80;
    localparam logic [LONG_W-1:0]  DEF_RESET_TAIL     = 10'd400;
    localparam logic [SHORT_W-1:0] DEF_WRITE_ONE_LOW  = 8'd10;
    localparam logic [SHORT_W-1:0] DEF_WRITE_ZERO_LOW = 8'd60;
    localparam logic [SHORT_W-1:0] DEF_WRITE_SLOT     = 8'd70;
    localparam logic [SHORT_W-1:0] DEF_READ_LOW       = 8'd2;
    localparam logic [SHORT_W-1:0] DEF_READ_SAMPLE    = 8'd10;

    localparam logic [LONG_W-1:0] READ_TAIL_TICKS = 10'd50;
    localparam logic [BITS_W-1:0] BITS_BYTE = 4'd8;
    localparam logic [BITS_W-1:0] BITS_ONE  = 4'd1;

    typedef struct packed {
        logic [LONG_W-1:0]  reset_low;
        logic [LONG_W-1:0]  presence_wait;
        logic [LONG_W-1:0]  reset_tail;
        logic [SHORT_W-1:0] write_one_low;
        logic [SHORT_W-1:0] write_zero_low;
        logic [SHORT_W-1:0] write_slot;
        logic [SHORT_W-1:0] read_low;
        logic [SHORT_W-1:0] read_sample;
    } t_cfg;

    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               done_res;
        logic               presence;
        logic [SHORT_W-1:0] read_byte;
        logic               rejected;
    } t_result;

endpackage

// ===== rtl/owm_cfg.sv =====
// Timing configuration registers of the 1-Wire bus master.
module owm_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [owm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [owm_pkg::LONG_W-1:0]      i_cfg_data,
    output owm_pkg::t_cfg                   o_cfg
);
    import owm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low      <= DEF_RESET_LOW;
            r_cfg.presence_wait  <= DEF_PRESENCE_WAIT;
            r_cfg.reset_tail     <= DEF_RESET_TAIL;
            r_cfg.write_one_low  <= DEF_WRITE_ONE_LOW;
            r_cfg.write_zero_low <= DEF_WRITE_ZERO_LOW;
            r_cfg.write_slot     <= DEF_WRITE_SLOT;
            r_cfg.read_low       <= DEF_READ_LOW;
            r_cfg.read_sample    <= DEF_READ_SAMPLE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RESET_LOW:      r_cfg.reset_low      <= i_cfg_data;
                CFG_PRESENCE_WAIT:  r_cfg.presence_wait  <= i_cfg_data;
                CFG_RESET_TAIL:     r_cfg.reset_tail     <= i_cfg_data;
                CFG_WRITE_ONE_LOW:  r_cfg.write_one_low  <= i_cfg_data[SHORT_W-1:0];
                CFG_WRITE_ZERO_LOW: r_cfg.write_zero_low <= i_cfg_data[SHORT_W-1:0];
                CFG_WRITE_SLOT:     r_cfg.write_slot     <= i_cfg_data[SHORT_W-1:0];
                CFG_READ_LOW:       r_cfg.read_low       <= i_cfg_data[SHORT_W-1:0];
                CFG_READ_SAMPLE:    r_cfg.read_sample    <= i_cfg_data[SHORT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/owm_core.sv =====
// Bus timing state machine that turns one registered item into one result.
module owm_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [owm_pkg::KIND_W-1:0]  i_kind,
    input  logic [owm_pkg::SHORT_W-1:0] i_data_byte,
    input  logic                       i_line_level,
    input  owm_pkg::t_cfg              i_cfg,
    output owm_pkg::t_result           o_result
);
    import owm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_HIGH  = 4'd5,
        PH_RD_LOW   = 4'd6,
        PH_RD_WAIT  = 4'd7,
        PH_RD_TAIL  = 4'd8
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [KIND_W-1:0]  r_op_kind, n_op_kind;
    logic [LONG_W-1:0]  r_tick_count, n_tick_count;
    logic [SHORT_W-1:0] r_shift_reg, n_shift_reg;
    logic [BITS_W-1:0]  r_bits_left, n_bits_left;
    logic               r_presence, n_presence;
    logic [SHORT_W-1:0] r_read_result, n_read_result;
    logic               n_done, n_rejected;
    logic [LONG_W-1:0]  w_count_inc;
    logic [LONG_W-1:0]  w_write_low;
    logic               w_busy;

    assign w_busy = (r_phase != PH_IDLE);
    assign w_count_inc = r_tick_count + 10'd1;
    assign w_write_low = r_shift_reg[0] ? {2'b00, i_cfg.write_one_low}
                                        : {2'b00, i_cfg.write_zero_low};

    always_comb begin
        n_phase       = r_phase;
        n_op_kind     = r_op_kind;
        n_tick_count  = r_tick_count;
        n_shift_reg   = r_shift_reg;
        n_bits_left   = r_bits_left;
        n_presence    = r_presence;
        n_read_result = r_read_result;
        n_done        = 1'b0;
        n_rejected    = 1'b0;
        if (i_kind == KIND_TICK) begin
            if (w_busy) begin
                n_tick_count = w_count_inc;
                unique case (r_phase)
                    PH_RST_LOW: begin
                        if (w_count_inc >= i_cfg.reset_low) begin
                            n_phase = PH_RST_WAIT;
                            n_tick_count = '0;
                        end
                    end
                    PH_RST_WAIT: begin
                        if (w_count_inc >= i_cfg.presence_wait) begin
                            n_presence = ~i_line_level;
                            n_phase = PH_RST_TAIL;
                            n_tick_count = '0;
                        end
                    end
                    PH_RST_TAIL: begin
                        if (w_count_inc >= i_cfg.reset_tail) begin
                            n_phase = PH_IDLE;
                            n_tick_count = '0;
                            n_done = 1'b1;
                        end
                    end
                    PH_WR_LOW, PH_WR_HIGH: begin
                        if (w_count_inc >= {2'b00, i_cfg.write_slot}
                            && (r_phase == PH_WR_HIGH || w_count_inc >= w_write_low)) begin
                            n_shift_reg = {1'b0, r_shift_reg[SHORT_W-1:1]};
                            n_tick_count = '0;
                            if (r_bits_left <= BITS_ONE) begin
                                n_bits_left = '0;
                                n_phase = PH_IDLE;
                                n_done = 1'b1;
                            end else begin
                                n_bits_left = r_bits_left - BITS_ONE;
                                n_phase = PH_WR_LOW;
                            end
                        end else if (r_phase == PH_WR_LOW && w_count_inc >= w_write_low) begin
                            n_phase = PH_WR_HIGH;
                        end
                    end
                    PH_RD_LOW: begin
                        if (w_count_inc >= {2'b00, i_cfg.read_low}) begin
                            n_phase = PH_RD_WAIT;
                            n_tick_count = '0;
                        end
                    end
                    PH_RD_WAIT: begin
                        if (w_count_inc >= {2'b00, i_cfg.read_sample}) begin
                            n_shift_reg = {i_line_level, r_shift_reg[SHORT_W-1:1]};
                            n_phase = PH_RD_TAIL;
                            n_tick_count = '0;
                        end
                    end
                    PH_RD_TAIL: begin
                        if (w_count_inc >= READ_TAIL_TICKS) begin
                            n_tick_count = '0;
                            if (r_bits_left <= BITS_ONE) begin
                                n_bits_left = '0;
                                n_read_result = (r_op_kind == KIND_RD_BYTE) ? r_shift_reg
                                    : {{(SHORT_W-1){1'b0}}, r_shift_reg[SHORT_W-1]};
                                n_phase = PH_IDLE;
                                n_done = 1'b1;
                            end else begin
                                n_bits_left = r_bits_left - BITS_ONE;
                                n_phase = PH_RD_LOW;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_tick_count = '0;
                    end
                endcase
            end
        end else if (i_kind <= KIND_RD_BIT) begin
            if (w_busy) begin
                n_rejected = 1'b1;
            end else begin
                n_op_kind = i_kind;
                n_tick_count = '0;
                unique case (i_kind)
                    KIND_RESET: begin
                        n_phase = PH_RST_LOW;
                        n_bits_left = '0;
                    end
                    KIND_WR_BYTE: begin
                        n_phase = PH_WR_LOW;
                        n_shift_reg = i_data_byte;
                        n_bits_left = BITS_BYTE;
                    end
                    KIND_RD_BYTE: begin
                        n_phase = PH_RD_LOW;
                        n_shift_reg = '0;
                        n_bits_left = BITS_BYTE;
                    end
                    KIND_WR_BIT: begin
                        n_phase = PH_WR_LOW;
                        n_shift_reg = {{(SHORT_W-1){1'b0}}, i_data_byte[0]};
                        n_bits_left = BITS_ONE;
                    end
                    default: begin
                        n_phase = PH_RD_LOW;
                        n_shift_reg = '0;
                        n_bits_left = BITS_ONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_op_kind     <= '0;
            r_tick_count  <= '0;
            r_shift_reg   <= '0;
            r_bits_left   <= '0;
            r_presence    <= 1'b0;
            r_read_result <= '0;
        end else if (i_en) begin
            r_phase       <= n_phase;
            r_op_kind     <= n_op_kind;
            r_tick_count  <= n_tick_count;
            r_shift_reg   <= n_shift_reg;
            r_bits_left   <= n_bits_left;
            r_presence    <= n_presence;
            r_read_result <= n_read_result;
        end
    end

    always_comb begin
        o_result.drive_low = (n_phase == PH_RST_LOW) || (n_phase == PH_WR_LOW)
                             || (n_phase == PH_RD_LOW);
        o_result.busy_res  = (n_phase != PH_IDLE);
        o_result.done_res  = n_done;
        o_result.presence  = n_presence;
        o_result.read_byte = n_read_result;
        o_result.rejected  = n_rejected;
    end

endmodule

// ===== rtl/one_wire_bus_master_top.sv =====
// 1-Wire bus master: input register, timing state machine and result register.
//
// Usage: each input item is either a one-microsecond tick (kind 0) that carries the
// sampled bus level, or a command: bus reset with presence detect, write byte, read
// byte, write bit or read bit. Bytes go least significant bit first.
// Every accepted item yields exactly one result item with the bus drive, busy, done,
// presence, read data and rejected flags as they stand after that item.
// A command given while an operation is in progress is rejected and changes nothing.
// Both channels use valid and stall; an item moves when valid is high and stall low.
// An item passes through the input register and then the result register.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register fills;
// input stall rises only when both are full and the result is not taken.
// Timing registers are written through the configuration port; the user must write
// them only while idle; the block does not enforce it. Synchronous reset empties
// both registers, puts the state machine in idle and loads default timing values.
module one_wire_bus_master_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [owm_pkg::KIND_W-1:0]      i_kind,
    input  logic [owm_pkg::SHORT_W-1:0]     i_data_byte,
    input  logic                            i_line_level,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_drive_low,
    output logic                            o_busy_res,
    output logic                            o_done_res,
    output logic                            o_presence,
    output logic [owm_pkg::SHORT_W-1:0]     o_read_byte,
    output logic                            o_rejected,
    input  logic                            i_cfg_we,
    input  logic [owm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [owm_pkg::LONG_W-1:0]      i_cfg_data
);
    import owm_pkg::*;

    logic               r_in_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [SHORT_W-1:0] r_data_byte;
    logic               r_line_level;
    logic               r_out_valid;
    t_result            r_result;
    t_result            w_result;
    t_cfg               w_cfg;
    logic               w_out_free;
    logic               w_advance;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    owm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    owm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_advance),
        .i_kind       (r_kind),
        .i_data_byte  (r_data_byte),
        .i_line_level (r_line_level),
        .i_cfg        (w_cfg),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_kind       <= i_kind;
            r_data_byte  <= i_data_byte;
            r_line_level <= i_line_level;
        end
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive_low = r_result.drive_low;
    assign o_busy_res  = r_result.busy_res;
    assign o_done_res  = r_result.done_res;
    assign o_presence  = r_result.presence;
    assign o_read_byte = r_result.read_byte;
    assign o_rejected  = r_result.rejected;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_drive_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_drive_low || o_busy_res))
        else $error("bus driven low while idle");

    a_done_ends_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_done_res || (!o_busy_res && !o_rejected)))
        else $error("done result with busy or rejected set");

    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_free) |=> r_out_valid)
        else $error("advanced item produced no result");

endmodule
